### hw/rtl/h2r_pkg.sv
package h2r_pkg;

	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int CH_W  = 8;
	localparam int FRAC_W = 6;
	localparam int QUO_W  = 4;

	localparam int PCT_MAX_I    = 100;
	localparam int SECTOR_DEG_I = 60;
	localparam int SECTORS_I    = 6;
	localparam int FULL_SCALE_I = 255;
	// Largest hue / 60 that a 9-bit hue can produce.
	localparam int QUO_MAX      = ((1 << HUE_W) - 1) / SECTOR_DEG_I;

	localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_MAX_I);

	// Widths of the intermediate terms.
	localparam int A_W  = 15;	// 255 * V, at most 25500
	localparam int NQ_W = 13;	// 6000 - F * S, at most 6000
	localparam int PP_W = 22;	// 255 * V * (100 - S)
	localparam int PQ_W = 28;	// 255 * V * (6000 - F * S)
	localparam int PV_W = 31;	// 255 * V times its reciprocal

	localparam int QT_FULL_I = PCT_MAX_I * SECTOR_DEG_I;

	// Reciprocals ceil(2^(N+l) / d) give an exact floor division for N-bit dividends.
	localparam int V_SHIFT = 22;	// d = 100, N = 15, l = 7
	localparam logic [15:0] V_RECIP = 16'd41944;
	localparam int P_SHIFT = 36;	// d = 10000, N = 22, l = 14
	localparam logic [22:0] P_RECIP = 23'd6871948;
	localparam int Q_SHIFT = 48;	// d = 600000, N = 28, l = 20
	localparam logic [28:0] Q_RECIP = 29'd469124962;

	localparam int VM_W = A_W + 16;
	localparam int PM_W = PP_W + 23;
	localparam int QM_W = PQ_W + 29;

	typedef enum logic [2:0] {
		SEC_RED_TO_YELLOW   = 3'd0,
		SEC_YELLOW_TO_GREEN = 3'd1,
		SEC_GREEN_TO_CYAN   = 3'd2,
		SEC_CYAN_TO_BLUE    = 3'd3,
		SEC_BLUE_TO_MAGENTA = 3'd4,
		SEC_MAGENTA_TO_RED  = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [FRAC_W-1:0] frac;
		logic [PCT_W-1:0]  sat;
		logic [PCT_W-1:0]  val;
	} s1_t;

	typedef struct packed {
		sector_t          sector;
		logic [A_W-1:0]   a;
		logic [PCT_W-1:0] np;
		logic [NQ_W-1:0]  nq;
		logic [NQ_W-1:0]  nt;
	} s2_t;

	typedef struct packed {
		sector_t         sector;
		logic [PP_W-1:0] pp;
		logic [PQ_W-1:0] pq;
		logic [PQ_W-1:0] pt;
		logic [PV_W-1:0] pv;
	} s3_t;

	typedef struct packed {
		sector_t         sector;
		logic [CH_W-1:0] cv;
		logic [CH_W-1:0] cp;
		logic [CH_W-1:0] cq;
		logic [CH_W-1:0] ct;
	} s4_t;

	// Stage handshake: the stage loads when en is high.
	typedef struct packed {
		logic valid;
		logic en;
	} stage_ctl_t;

endpackage

### hw/rtl/h2r_sector.sv
module h2r_sector (
	input  logic                      clk,
	input  logic                      arst_n,
	input  h2r_pkg::stage_ctl_t       ctl,
	input  logic [h2r_pkg::HUE_W-1:0] hue,
	input  logic [h2r_pkg::PCT_W-1:0] sat,
	input  logic [h2r_pkg::PCT_W-1:0] val,
	output logic                      valid_s1,
	output h2r_pkg::s1_t              data_s1
);
	import h2r_pkg::*;

	logic [PCT_W-1:0] sat_c;
	logic [PCT_W-1:0] val_c;
	logic [QUO_W-1:0] quo;
	logic [HUE_W-1:0] quo_deg;
	logic [QUO_W-1:0] sec_raw;

	always_comb begin
		sat_c = (sat > PCT_MAX) ? PCT_MAX : sat;
		val_c = (val > PCT_MAX) ? PCT_MAX : val;
		// The thresholds are independent compares; the last one met gives hue / 60.
		quo = '0;
		for (int k = 1; k <= QUO_MAX; k++) begin
			if (hue >= HUE_W'(k * SECTOR_DEG_I)) begin
				quo = QUO_W'(k);
			end
		end
		quo_deg = HUE_W'(quo) * HUE_W'(SECTOR_DEG_I);
		sec_raw = (quo >= QUO_W'(SECTORS_I)) ? quo - QUO_W'(SECTORS_I) : quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_s1.sector <= sector_t'(sec_raw[2:0]);
			data_s1.frac   <= FRAC_W'(hue - quo_deg);
			data_s1.sat    <= sat_c;
			data_s1.val    <= val_c;
		end
	end

endmodule

### hw/rtl/h2r_terms.sv
module h2r_terms (
	input  logic                clk,
	input  logic                arst_n,
	input  h2r_pkg::stage_ctl_t ctl,
	input  h2r_pkg::s1_t        data_s1,
	output logic                valid_s2,
	output h2r_pkg::s2_t        data_s2
);
	import h2r_pkg::*;

	logic [NQ_W-1:0] fq;
	logic [NQ_W-1:0] ft;

	always_comb begin
		fq = NQ_W'(data_s1.frac) * NQ_W'(data_s1.sat);
		ft = NQ_W'(FRAC_W'(SECTOR_DEG_I) - data_s1.frac) * NQ_W'(data_s1.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctl.en) begin
			valid_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_s2.sector <= data_s1.sector;
			data_s2.a      <= A_W'(data_s1.val) * A_W'(FULL_SCALE_I);
			data_s2.np     <= PCT_MAX - data_s1.sat;
			data_s2.nq     <= NQ_W'(QT_FULL_I) - fq;
			data_s2.nt     <= NQ_W'(QT_FULL_I) - ft;
		end
	end

endmodule

### hw/rtl/h2r_prod.sv
module h2r_prod (
	input  logic                clk,
	input  logic                arst_n,
	input  h2r_pkg::stage_ctl_t ctl,
	input  h2r_pkg::s2_t        data_s2,
	output logic                valid_s3,
	output h2r_pkg::s3_t        data_s3
);
	import h2r_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ctl.en) begin
			valid_s3 <= ctl.valid;
		end
	end

	// Four independent products, each one multiplier deep.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_s3.sector <= data_s2.sector;
			data_s3.pp     <= PP_W'(data_s2.a) * PP_W'(data_s2.np);
			data_s3.pq     <= PQ_W'(data_s2.a) * PQ_W'(data_s2.nq);
			data_s3.pt     <= PQ_W'(data_s2.a) * PQ_W'(data_s2.nt);
			data_s3.pv     <= PV_W'(data_s2.a) * PV_W'(V_RECIP);
		end
	end

endmodule

### hw/rtl/h2r_scale.sv
module h2r_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  h2r_pkg::stage_ctl_t ctl,
	input  h2r_pkg::s3_t        data_s3,
	output logic                valid_s4,
	output h2r_pkg::s4_t        data_s4
);
	import h2r_pkg::*;

	logic [PM_W-1:0] mp;
	logic [QM_W-1:0] mq;
	logic [QM_W-1:0] mt;

	// Division by a constant as a multiply by its reciprocal; the quotient is a bit field.
	always_comb begin
		mp = PM_W'(data_s3.pp) * PM_W'(P_RECIP);
		mq = QM_W'(data_s3.pq) * QM_W'(Q_RECIP);
		mt = QM_W'(data_s3.pt) * QM_W'(Q_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ctl.en) begin
			valid_s4 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			data_s4.sector <= data_s3.sector;
			data_s4.cv     <= data_s3.pv[V_SHIFT +: CH_W];
			data_s4.cp     <= mp[P_SHIFT +: CH_W];
			data_s4.cq     <= mq[Q_SHIFT +: CH_W];
			data_s4.ct     <= mt[Q_SHIFT +: CH_W];
		end
	end

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter. Each input word carries a hue in degrees, a saturation
// percent and a value percent; each output word carries 8-bit red, green and blue,
// each the truncated 255 times its component. Percentages above 100 count as 100
// and hue wraps every 360 degrees. The block takes one word per clock while the
// output is not stalled and passes it through a five-stage pipeline (sector split,
// terms, products, reciprocal scaling, channel select into the output register).
// When the output is stalled, stages fill up behind it and input ready drops only
// once every stage holds a word.
module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,	// hue_degrees[8:0], saturation_pct[15:9], value_pct[22:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata	// red[7:0], green[15:8], blue[23:16]
);
	import h2r_pkg::*;

	logic       valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic       en1, en2, en3, en4, en5;
	s1_t        data_s1;
	s2_t        data_s2;
	s3_t        data_s3;
	s4_t        data_s4;
	logic [CH_W-1:0] red_s5, green_s5, blue_s5;
	logic [CH_W-1:0] red_d, green_d, blue_d;
	stage_ctl_t ctl1, ctl2, ctl3, ctl4;

	// A stage loads when it is empty or when the one after it loads.
	assign en5 = !valid_s5 || m_axis_tready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign s_axis_tready = en1;

	assign ctl1 = '{valid: s_axis_tvalid, en: en1};
	assign ctl2 = '{valid: valid_s1, en: en2};
	assign ctl3 = '{valid: valid_s2, en: en3};
	assign ctl4 = '{valid: valid_s3, en: en4};

	h2r_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl1),
		.hue      (s_axis_tdata[8:0]),
		.sat      (s_axis_tdata[15:9]),
		.val      (s_axis_tdata[22:16]),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	h2r_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl2),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	h2r_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl3),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	h2r_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl4),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	always_comb begin
		case (data_s4.sector)
			SEC_RED_TO_YELLOW: begin
				red_d = data_s4.cv; green_d = data_s4.ct; blue_d = data_s4.cp;
			end
			SEC_YELLOW_TO_GREEN: begin
				red_d = data_s4.cq; green_d = data_s4.cv; blue_d = data_s4.cp;
			end
			SEC_GREEN_TO_CYAN: begin
				red_d = data_s4.cp; green_d = data_s4.cv; blue_d = data_s4.ct;
			end
			SEC_CYAN_TO_BLUE: begin
				red_d = data_s4.cp; green_d = data_s4.cq; blue_d = data_s4.cv;
			end
			SEC_BLUE_TO_MAGENTA: begin
				red_d = data_s4.ct; green_d = data_s4.cp; blue_d = data_s4.cv;
			end
			default: begin
				red_d = data_s4.cv; green_d = data_s4.cp; blue_d = data_s4.cq;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {blue_s5, green_s5, red_s5};

	// A ready output frees every stage behind it.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// A new output word must come out of a full fourth stage.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s4))
		else $error("output word appeared without a word in stage four");

	// A held first stage keeps its word.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s_axis_tready) |=> valid_s1)
		else $error("stage one dropped a word while stalled");

endmodule
